[rtl/aes_pkg.sv]
// Shared types, tables and round functions of the AES-128 block cipher.
package aes_pkg;

   localparam int NumRounds = 10;
   localparam int NumKeys   = NumRounds + 1;
   localparam int StepW     = $clog2(NumKeys);

   localparam logic       KindEncrypt = 1'b0;
   localparam logic       KindDecrypt = 1'b1;
   localparam logic       CsrKeyHigh  = 1'b0;
   localparam logic       CsrKeyLow   = 1'b1;
   localparam logic [7:0] RconFirst   = 8'h01;
   localparam logic [7:0] GfPoly      = 8'h1b;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_ROUND
   } fsm_type;

   typedef enum logic [1:0] {
      SHIFT_HOLD,
      SHIFT_FWD,
      SHIFT_BWD
   } key_shift_type;

   typedef struct packed {
      logic load;
      logic step;
      logic first;
      logic last;
      logic inv;
   } round_ctl_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   // byte 0 sits in the top bits of the 128-bit word
   function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
      return s[127 - 8 * i -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
   endfunction

   function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
      logic [127:0] o;
      o = '0;
      for (int i = 0; i < 16; i++) begin
         o[127 - 8 * i -: 8] = inv ? INV_SBOX[get_byte(s, i)] : SBOX[get_byte(s, i)];
      end
      return o;
   endfunction

   function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
      logic [127:0] o;
      o = '0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            if (inv) begin
               o[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = get_byte(s, r + 4 * c);
            end else begin
               o[127 - 8 * (r + 4 * c) -: 8] = get_byte(s, r + 4 * ((c + r) % 4));
            end
         end
      end
      return o;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
      logic [127:0] o;
      logic [7:0]   a [4];
      logic [7:0]   x1 [4];
      logic [7:0]   x2 [4];
      logic [7:0]   x3 [4];
      logic [7:0]   v;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 4; j++) begin
            a[j]  = get_byte(s, 4 * c + j);
            x1[j] = xtime(a[j]);
            x2[j] = xtime(x1[j]);
            x3[j] = xtime(x2[j]);
         end
         for (int r = 0; r < 4; r++) begin
            if (inv) begin
               // 14, 11, 13, 9 along the row
               v = (x3[r] ^ x2[r] ^ x1[r])
                 ^ (x3[(r + 1) % 4] ^ x1[(r + 1) % 4] ^ a[(r + 1) % 4])
                 ^ (x3[(r + 2) % 4] ^ x2[(r + 2) % 4] ^ a[(r + 2) % 4])
                 ^ (x3[(r + 3) % 4] ^ a[(r + 3) % 4]);
            end else begin
               // 2, 3, 1, 1 along the row
               v = x1[r] ^ (x1[(r + 1) % 4] ^ a[(r + 1) % 4])
                 ^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
            end
            o[127 - 8 * (4 * c + r) -: 8] = v;
         end
      end
      return o;
   endfunction

   // one step of the key schedule
   function automatic logic [127:0] next_round_key(input logic [127:0] w,
                                                   input logic [7:0]   rcon);
      logic [31:0] t;
      logic [31:0] w0;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] w3;
      t  = {SBOX[get_byte(w, 13)] ^ rcon, SBOX[get_byte(w, 14)],
            SBOX[get_byte(w, 15)], SBOX[get_byte(w, 12)]};
      w0 = w[127:96] ^ t;
      w1 = w[95:64] ^ w0;
      w2 = w[63:32] ^ w1;
      w3 = w[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage

[rtl/aes_if.sv]
// Handshake channel interfaces: block requests, results and key writes.
interface aes_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [63:0] block_high;
   logic [63:0] block_low;
   logic        last_block;
   modport source (output valid, kind, block_high, block_low, last_block, input ready);
   modport sink   (input valid, kind, block_high, block_low, last_block, output ready);
endinterface

interface aes_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_high;
   logic [63:0] result_low;
   logic        last_out;
   modport source (output valid, result_high, result_low, last_out, input ready);
   modport sink   (input valid, result_high, result_low, last_out, output ready);
endinterface

interface aes_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/aes_key_cell.sv]
// One cell of the round key ring: holds a round key, takes it from either neighbour.
module aes_key_cell (
   input  logic                   clock,
   input  aes_pkg::key_shift_type shift,
   input  logic [127:0]           from_left,
   input  logic [127:0]           from_right,
   output logic [127:0]           key
);

   logic [127:0] key_ff;
   logic [127:0] key_in;

   always_comb begin
      case (shift)
         aes_pkg::SHIFT_FWD: key_in = from_right;
         aes_pkg::SHIFT_BWD: key_in = from_left;
         default:            key_in = key_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key = key_ff;

endmodule

[rtl/aes_round_unit.sv]
// Shared round datapath: holds the cipher state and applies one round per step.
module aes_round_unit (
   input  logic                   clock,
   input  aes_pkg::round_ctl_type ctl,
   input  logic [127:0]           block,
   input  logic [127:0]           round_key,
   output logic [127:0]           round_out
);

   logic [127:0] state_ff;
   logic [127:0] state_in;
   logic [127:0] core;

   always_comb begin
      if (ctl.first) begin
         core = state_ff;
      end else if (ctl.inv) begin
         core = aes_pkg::sub_bytes(aes_pkg::shift_rows(state_ff, 1'b1), 1'b1);
      end else begin
         core = aes_pkg::shift_rows(aes_pkg::sub_bytes(state_ff, 1'b0), 1'b0);
         // forward middle rounds mix before the key
         if (!ctl.last) begin
            core = aes_pkg::mix_columns(core, 1'b0);
         end
      end
      core = core ^ round_key;
      // inverse middle rounds mix after the key
      if (ctl.inv && !ctl.first && !ctl.last) begin
         core = aes_pkg::mix_columns(core, 1'b1);
      end
      round_out = core;
   end

   always_comb begin
      if (ctl.load) begin
         state_in = block;
      end else if (ctl.step) begin
         state_in = round_out;
      end else begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

endmodule

[rtl/aes128_block_cipher_top.sv]
// Top level of the AES-128 ECB block cipher with a ring of round key cells.
// A request is taken only in the idle state, as the single shared round unit works on one
// item at a time: the block is loaded, then 11 round steps run, the last one waiting for the
// result register to drain. Key expansion into the ring comes first after a key write.
// Reset: synchronous, active high; key registers read as zero, schedule marked stale,
// no result pending. The round key ring itself is not reset.
module aes128_block_cipher_top (
   input  logic      clock,
   input  logic      reset,
   aes_req_if.sink   req_chan,
   aes_rsp_if.source rsp_chan,
   aes_csr_if.sink   csr_chan
);

   localparam int LastCell = aes_pkg::NumKeys - 1;

   // control
   aes_pkg::fsm_type             fsm_ff, fsm_in;
   logic [aes_pkg::StepW-1:0]    cnt_ff, cnt_in;
   logic                         sched_ok_ff, sched_ok_in;
   logic                         kind_ff;
   logic                         last_ff;
   logic                         req_take;
   logic                         step_fire;
   logic                         out_free;

   // key registers and expansion
   logic [63:0]                  key_high_ff;
   logic [63:0]                  key_low_ff;
   logic [127:0]                 wk_ff, wk_in;
   logic [7:0]                   rcon_ff, rcon_in;

   // round key ring
   aes_pkg::key_shift_type       shift;
   logic [127:0]                 cell_key [aes_pkg::NumKeys];
   logic [127:0]                 tail_in;
   logic [127:0]                 round_key;

   // round unit
   aes_pkg::round_ctl_type       rctl;
   logic [127:0]                 round_out;

   // result register
   logic                         rsp_valid_ff;
   logic [127:0]                 rsp_data_ff;
   logic                         rsp_last_ff;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = (fsm_ff == aes_pkg::ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // the last round step waits for the result register to drain
   assign step_fire = (fsm_ff == aes_pkg::ST_ROUND)
                    && ((cnt_ff != aes_pkg::StepW'(aes_pkg::NumRounds)) || out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            aes_pkg::CsrKeyHigh: key_high_ff <= csr_chan.data;
            aes_pkg::CsrKeyLow:  key_low_ff  <= csr_chan.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      fsm_in      = fsm_ff;
      cnt_in      = cnt_ff;
      sched_ok_in = sched_ok_ff;
      wk_in       = wk_ff;
      rcon_in     = rcon_ff;
      shift       = aes_pkg::SHIFT_HOLD;
      rctl        = '0;
      rctl.inv    = (kind_ff == aes_pkg::KindDecrypt);
      rctl.first  = (cnt_ff == '0);
      rctl.last   = (cnt_ff == aes_pkg::StepW'(aes_pkg::NumRounds));
      case (fsm_ff)
         aes_pkg::ST_IDLE: begin
            if (req_take) begin
               rctl.load = 1'b1;
               cnt_in    = '0;
               wk_in     = {key_high_ff, key_low_ff};
               rcon_in   = aes_pkg::RconFirst;
               fsm_in    = sched_ok_ff ? aes_pkg::ST_ROUND : aes_pkg::ST_EXPAND;
            end
         end
         aes_pkg::ST_EXPAND: begin
            // push the current key into the ring tail, derive the next one
            shift   = aes_pkg::SHIFT_FWD;
            wk_in   = aes_pkg::next_round_key(wk_ff, rcon_ff);
            rcon_in = aes_pkg::xtime(rcon_ff);
            if (cnt_ff == aes_pkg::StepW'(LastCell)) begin
               cnt_in      = '0;
               sched_ok_in = 1'b1;
               fsm_in      = aes_pkg::ST_ROUND;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         aes_pkg::ST_ROUND: begin
            if (step_fire) begin
               rctl.step = 1'b1;
               shift     = rctl.inv ? aes_pkg::SHIFT_BWD : aes_pkg::SHIFT_FWD;
               if (rctl.last) begin
                  cnt_in = '0;
                  fsm_in = aes_pkg::ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: fsm_in = aes_pkg::ST_IDLE;
      endcase
      // a key write makes the stored schedule stale
      if (csr_chan.valid && csr_chan.ready) begin
         sched_ok_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff      <= aes_pkg::ST_IDLE;
         cnt_ff      <= '0;
         sched_ok_ff <= 1'b0;
      end else begin
         fsm_ff      <= fsm_in;
         cnt_ff      <= cnt_in;
         sched_ok_ff <= sched_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      wk_ff   <= wk_in;
      rcon_ff <= rcon_in;
      if (req_take) begin
         kind_ff <= req_chan.kind;
         last_ff <= req_chan.last_block;
      end
   end

   // ring: forward shifts move keys toward cell 0, backward toward the last cell.
   // Eleven rotations bring the ring back to key r in cell r.
   assign tail_in = (fsm_ff == aes_pkg::ST_EXPAND) ? wk_ff : cell_key[0];

   for (genvar i = 0; i < aes_pkg::NumKeys; i++) begin : g_cell
      aes_key_cell u_cell (
         .clock      (clock),
         .shift      (shift),
         .from_left  ((i == 0) ? cell_key[LastCell] : cell_key[(i + LastCell) % aes_pkg::NumKeys]),
         .from_right ((i == LastCell) ? tail_in : cell_key[(i + 1) % aes_pkg::NumKeys]),
         .key        (cell_key[i])
      );
   end

   // encryption reads from the head, decryption from the tail
   assign round_key = rctl.inv ? cell_key[LastCell] : cell_key[0];

   aes_round_unit u_round (
      .clock     (clock),
      .ctl       (rctl),
      .block     ({req_chan.block_high, req_chan.block_low}),
      .round_key (round_key),
      .round_out (round_out)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_fire && rctl.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire && rctl.last) begin
         rsp_data_ff <= round_out;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.result_high = rsp_data_ff[127:64];
   assign rsp_chan.result_low  = rsp_data_ff[63:0];
   assign rsp_chan.last_out    = rsp_last_ff;

endmodule
